/* rtl/core/max_height_grid_fuser_defines.svh */
// Assertion macros shared by the grid fuser files
`ifndef MAX_HEIGHT_GRID_FUSER_DEFINES_SVH
`define MAX_HEIGHT_GRID_FUSER_DEFINES_SVH

`define MHGF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define MHGF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mhgf_pkg.sv */
package mhgf_pkg;

  typedef enum logic [1:0] {
    CMD_FUSE  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_HALF_X = 3'd0,
    REG_HALF_Y = 3'd1,
    REG_COL_SCALE = 3'd2,
    REG_ROW_SCALE = 3'd3,
    REG_OFFSET = 3'd4,
    REG_FLOOR = 3'd5,
    REG_GAIN = 3'd6,
    REG_SPARE = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_NORM
  } back_state_t;

  typedef struct packed {
    logic              fuse;
    logic              read;
    logic signed [15:0] height;
    logic [9:0]        row;
    logic [9:0]        column;
  } op_t;

  localparam int unsigned QUEUE_DEPTH = 4;

endpackage

/* rtl/core/max_height_grid_fuser.sv */
// Maximum-height grid fuser.
// Commands enter on start when busy is low: fuse a point, begin readout,
// or read-and-clear one cell. A fuse gives no answer.
// A begin answer (result_kind 0, frame_pending) is strobed in the cycle after
// acceptance. A read answer (result_kind 1, height_norm) is strobed once the
// queue drains to it. Points pass a two-stage binning pipe into a four-entry
// queue; the cell engine takes one queued operation at a time, through an
// idle and a read state (plus a norm state for a read), limited by the
// single-port cell memory's read-modify-write. busy rises when the queue is
// nearly full, so a point stream is paced by the cell engine. busy also holds
// from a read's acceptance until its answer has been strobed, so answers
// leave in command order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// while idle.
// After reset the engine clears all GRID_ROWS*GRID_COLUMNS cells, one a cycle;
// busy stays high meanwhile.
// Results are strobed for one cycle; the receiver cannot stall them.
module max_height_grid_fuser #(
  parameter int unsigned GRID_ROWS = 160,
  parameter int unsigned GRID_COLUMNS = 160
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  input  logic               z_is_valid,
  input  logic [7:0]         read_row,
  input  logic [7:0]         read_column,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               strobe,
  output logic               result_kind,
  output logic               frame_pending,
  output logic [15:0]        height_norm
);

  logic [14:0]        half_span_x;
  logic [14:0]        half_span_y;
  logic [15:0]        column_scale;
  logic [15:0]        row_scale;
  logic signed [15:0] height_offset;
  logic signed [15:0] height_floor;
  logic [23:0]        height_gain;
  logic               take;
  logic               op_valid;
  mhgf_pkg::op_t      op_in;
  mhgf_pkg::op_t      op_head;
  logic               q_not_empty;
  logic               q_almost_full;
  logic               q_pop;
  logic               clearing;
  logic               status_strobe;
  logic               status_pending;
  logic               cell_strobe;
  logic [15:0]        cell_norm;
  logic               read_open;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_span_x <= 15'd3000;
      half_span_y <= 15'd3000;
      column_scale <= 16'd1748;
      row_scale <= 16'd1748;
      height_offset <= 16'sd1000;
      height_floor <= 16'sd0;
      height_gain <= 24'd4294967;
    end else if (cfg_valid) begin
      unique case (mhgf_pkg::reg_idx_t'(cfg_index))
        mhgf_pkg::REG_HALF_X: half_span_x <= cfg_data[14:0];
        mhgf_pkg::REG_HALF_Y: half_span_y <= cfg_data[14:0];
        mhgf_pkg::REG_COL_SCALE: column_scale <= cfg_data[15:0];
        mhgf_pkg::REG_ROW_SCALE: row_scale <= cfg_data[15:0];
        mhgf_pkg::REG_OFFSET: height_offset <= cfg_data[15:0];
        mhgf_pkg::REG_FLOOR: height_floor <= cfg_data[15:0];
        mhgf_pkg::REG_GAIN: height_gain <= cfg_data;
        mhgf_pkg::REG_SPARE: ;
        default: ;
      endcase
    end
  end

  // Hold new commands while a read transaction waits for its answer.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_open <= 1'b0;
    end else if (take && mhgf_pkg::cmd_t'(command) == mhgf_pkg::CMD_READ) begin
      read_open <= 1'b1;
    end else if (cell_strobe) begin
      read_open <= 1'b0;
    end
  end

  assign busy = clearing || q_almost_full || read_open;
  assign take = start && !busy;

  mhgf_front #(.ROWS(GRID_ROWS), .COLUMNS(GRID_COLUMNS)) u_front (
    .clk, .rst, .take,
    .cmd(mhgf_pkg::cmd_t'(command)),
    .point_x, .point_y, .point_z, .z_is_valid, .read_row, .read_column,
    .half_span_x, .half_span_y, .column_scale, .row_scale, .height_offset,
    .op_valid, .op(op_in), .status_strobe, .status_pending
  );

  mhgf_queue u_queue (
    .clk, .rst, .push(op_valid), .push_op(op_in), .pop(q_pop),
    .not_empty(q_not_empty), .almost_full(q_almost_full), .head(op_head)
  );

  mhgf_back #(.ROWS(GRID_ROWS), .COLUMNS(GRID_COLUMNS)) u_back (
    .clk, .rst, .op_ready(q_not_empty), .op(op_head), .op_pop(q_pop),
    .clearing, .height_floor, .height_gain, .cell_strobe, .cell_norm
  );

  // Only one answer lands in a cycle: no begin is taken while a read is open.
  always_comb begin
    strobe = status_strobe || cell_strobe;
    result_kind = !status_strobe;
    frame_pending = status_strobe ? status_pending : 1'b0;
    height_norm = status_strobe ? 16'd0 : cell_norm;
  end

endmodule

/* rtl/core/mhgf_front.sv */
// Classify each command, bin points and hand cell operations to the queue.
module mhgf_front #(
  parameter int unsigned ROWS = 160,
  parameter int unsigned COLUMNS = 160
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  mhgf_pkg::cmd_t      cmd,
  input  logic signed [15:0]  point_x,
  input  logic signed [15:0]  point_y,
  input  logic signed [15:0]  point_z,
  input  logic                z_is_valid,
  input  logic [7:0]          read_row,
  input  logic [7:0]          read_column,
  input  logic [14:0]         half_span_x,
  input  logic [14:0]         half_span_y,
  input  logic [15:0]         column_scale,
  input  logic [15:0]         row_scale,
  input  logic signed [15:0]  height_offset,
  output logic                op_valid,
  output mhgf_pkg::op_t       op,
  output logic                status_strobe,
  output logic                status_pending
);

  logic               pending;
  logic               s1_fuse;
  logic               s1_read;
  logic               s1_in;
  logic [15:0]        s1_dx;
  logic [15:0]        s1_dy;
  logic signed [15:0] s1_h;
  logic [9:0]         s1_row;
  logic [9:0]         s1_col;
  logic signed [16:0] lo_x;
  logic signed [16:0] lo_y;
  logic signed [16:0] hx;
  logic signed [16:0] hy;
  logic signed [16:0] hsum;
  logic signed [15:0] hsat;
  logic               in_x;
  logic               in_y;
  logic [31:0]        prod_x;
  logic [31:0]        prod_y;
  logic [15:0]        col_raw;
  logic [15:0]        row_raw;
  logic [9:0]         col_c;
  logic [9:0]         row_c;
  logic [9:0]         rd_row;
  logic [9:0]         rd_col;

  always_comb begin
    hx = {2'b00, half_span_x};
    hy = {2'b00, half_span_y};
    lo_x = {point_x[15], point_x};
    lo_y = {point_y[15], point_y};
    in_x = (lo_x >= -hx) && (lo_x < hx);
    in_y = (lo_y >= -hy) && (lo_y < hy);
    hsum = {point_z[15], point_z} + {height_offset[15], height_offset};
    if (hsum > 17'sd32767) begin
      hsat = 16'sh7fff;
    end else if (hsum < -17'sd32768) begin
      hsat = -16'sh8000;
    end else begin
      hsat = hsum[15:0];
    end
    rd_row = ({3'b000, read_row} >= 11'(ROWS)) ? 10'(ROWS - 1) : {2'b00, read_row};
    rd_col = ({3'b000, read_column} >= 11'(COLUMNS)) ? 10'(COLUMNS - 1)
                                                      : {2'b00, read_column};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      s1_fuse <= 1'b0;
      s1_read <= 1'b0;
      status_strobe <= 1'b0;
    end else begin
      s1_fuse <= take && (cmd == mhgf_pkg::CMD_FUSE) && z_is_valid && in_x && in_y;
      s1_read <= take && (cmd == mhgf_pkg::CMD_READ);
      status_strobe <= take && (cmd == mhgf_pkg::CMD_BEGIN);
      if (take && cmd == mhgf_pkg::CMD_FUSE) begin
        pending <= 1'b1;
      end else if (take && cmd == mhgf_pkg::CMD_BEGIN) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_pending <= pending;
    s1_dx <= 16'(lo_x + hx);
    s1_dy <= 16'(lo_y + hy);
    s1_h <= hsat;
    s1_row <= rd_row;
    s1_col <= rd_col;
    s1_in <= 1'b1;
  end

  // Stage two: scale offsets into bin indices and clamp.
  always_comb begin
    prod_x = s1_dx * column_scale;
    prod_y = s1_dy * row_scale;
    col_raw = prod_x[31:16];
    row_raw = prod_y[31:16];
    col_c = (col_raw >= 16'(COLUMNS)) ? 10'(COLUMNS - 1) : col_raw[9:0];
    row_c = (row_raw >= 16'(ROWS)) ? 10'(ROWS - 1) : row_raw[9:0];
    op_valid = (s1_fuse || s1_read) && s1_in;
    op.fuse = s1_fuse;
    op.read = s1_read;
    op.height = s1_h;
    op.row = s1_fuse ? row_c : s1_row;
    op.column = s1_fuse ? col_c : s1_col;
  end

endmodule

/* rtl/core/mhgf_queue.sv */
`include "max_height_grid_fuser_defines.svh"
// Small FIFO between the front and the cell engine.
module mhgf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mhgf_pkg::op_t push_op,
  input  logic          pop,
  output logic          not_empty,
  output logic          almost_full,
  output mhgf_pkg::op_t head
);

  localparam int unsigned AW = $clog2(mhgf_pkg::QUEUE_DEPTH);

  mhgf_pkg::op_t  slots [mhgf_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  assign head = slots[rd_ptr];
  assign not_empty = (count != '0);
  // Leave room for the two operations already inside the front pipeline.
  assign almost_full = (count >= (AW+1)'(mhgf_pkg::QUEUE_DEPTH - 2));

  `MHGF_ASSERT(a_no_overflow, push && !pop |-> count < (AW+1)'(mhgf_pkg::QUEUE_DEPTH), "queue overflow")
  `MHGF_ASSERT(a_no_underflow, pop |-> count != '0, "queue underflow")
  `MHGF_ASSERT(a_count_step, !push && !pop |=> $stable(count), "queue count drift")

endmodule

/* rtl/core/mhgf_back.sv */
`include "max_height_grid_fuser_defines.svh"
// Cell engine: clears the store after reset, then runs read-modify-write
// on one cell per operation over the single-port memory.
module mhgf_back #(
  parameter int unsigned ROWS = 160,
  parameter int unsigned COLUMNS = 160
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_ready,
  input  mhgf_pkg::op_t      op,
  output logic               op_pop,
  output logic               clearing,
  input  logic signed [15:0] height_floor,
  input  logic [23:0]        height_gain,
  output logic               cell_strobe,
  output logic [15:0]        cell_norm
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [16:0]              mem [CELLS];
  mhgf_pkg::back_state_t    state;
  mhgf_pkg::back_state_t    state_next;
  logic [AW-1:0]            clr_addr;
  logic [AW-1:0]            addr;
  logic [AW-1:0]            cur_addr;
  logic                     cur_fuse;
  logic signed [15:0]       cur_h;
  logic [16:0]              rd_data;
  logic                     we;
  logic [16:0]              wd;
  logic signed [16:0]       diff;
  logic [16:0]              d_reg;
  logic                     d_pos;
  logic [40:0]              prod;

  always_comb begin
    addr = AW'(op.row * 20'(COLUMNS) + 20'(op.column));
  end

  always_comb begin
    state_next = state;
    op_pop = 1'b0;
    we = 1'b0;
    wd = '0;
    unique case (state)
      mhgf_pkg::BK_CLEAR: begin
        we = 1'b1;
        if (clr_addr == AW'(CELLS - 1)) state_next = mhgf_pkg::BK_IDLE;
      end
      mhgf_pkg::BK_IDLE: begin
        if (op_ready) begin
          op_pop = 1'b1;
          state_next = mhgf_pkg::BK_READ;
        end
      end
      mhgf_pkg::BK_READ: begin
        we = 1'b1;
        if (cur_fuse) begin
          if (!rd_data[16] || cur_h > $signed(rd_data[15:0])) begin
            wd = {1'b1, cur_h};
          end else begin
            wd = rd_data;
          end
          state_next = mhgf_pkg::BK_IDLE;
        end else begin
          wd = '0;
          state_next = mhgf_pkg::BK_NORM;
        end
      end
      mhgf_pkg::BK_NORM: begin
        state_next = mhgf_pkg::BK_IDLE;
      end
      default: state_next = mhgf_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhgf_pkg::BK_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == mhgf_pkg::BK_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mhgf_pkg::BK_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[cur_addr] <= wd;
    end
    if (op_pop) begin
      rd_data <= mem[addr];
      cur_addr <= addr;
      cur_fuse <= op.fuse;
      cur_h <= op.height;
    end
  end

  // Normalise: difference registered, then one 17x24 multiply.
  always_comb begin
    diff = {rd_data[15], rd_data[15:0]} - {height_floor[15], height_floor};
    prod = d_reg * height_gain;
    if (!d_pos) begin
      cell_norm = '0;
    end else if (prod[40:32] != '0) begin
      cell_norm = 16'hffff;
    end else begin
      cell_norm = prod[31:16];
    end
  end

  always_ff @(posedge clk) begin
    d_reg <= diff;
    d_pos <= rd_data[16] && (diff > 17'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_strobe <= 1'b0;
    end else begin
      cell_strobe <= (state == mhgf_pkg::BK_READ) && !cur_fuse;
    end
  end

  assign clearing = (state == mhgf_pkg::BK_CLEAR);

  `MHGF_ASSERT(a_pop_idle, op_pop |-> state == mhgf_pkg::BK_IDLE, "pop outside idle")
  `MHGF_ASSERT(a_read_norm, state == mhgf_pkg::BK_READ && !cur_fuse |=> state == mhgf_pkg::BK_NORM, "read skipped norm")
  `MHGF_ASSERT_RST(a_reset_clear, rst |=> state == mhgf_pkg::BK_CLEAR, "reset did not clear")

endmodule
